>>> rtl/core/sebc_pkg.sv
// ----------------------------------------------------------------------------
// sebc_pkg
// Types, codes and constants shared by the escape byte-stuffing codec.
// ----------------------------------------------------------------------------
`default_nettype none

package sebc_pkg;

  // Bus control bytes.
  localparam logic [7:0] SyncCode    = 8'hFF;
  localparam logic [7:0] EscCode     = 8'h55;
  localparam logic [7:0] EscSyncCode = 8'h00;
  localparam logic [7:0] EscEscCode  = 8'h01;

  // Operation codes carried by an input item.
  localparam logic [1:0] OpEncData = 2'd0;
  localparam logic [1:0] OpEncSync = 2'd1;
  localparam logic [1:0] OpDecode  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KindWire = 2'd0;
  localparam logic [1:0] KindData = 2'd1;
  localparam logic [1:0] KindSync = 2'd2;

  // Default depth of the command queue between front and back end.
  localparam int QueueDepthDefault = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last;
  } out_item_t;

  // One classified command: one or two result bytes of the same kind.
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] kind;
    logic       two;
  } cmd_t;

  // Push side of the command queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

endpackage

`default_nettype wire

>>> rtl/core/sebc_front.sv
// ----------------------------------------------------------------------------
// sebc_front
// Accepts input items, classifies them and holds the receive escape state.
// ----------------------------------------------------------------------------
`default_nettype none

module sebc_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sebc_pkg::in_item_t    in_item,
  input  wire                   queue_full,
  output sebc_pkg::cmd_push_t   push
);
  import sebc_pkg::*;

  logic rx_escape_pending;
  logic rx_escape_pending_next;
  logic accept;
  logic emit;
  cmd_t cmd;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    emit                   = 1'b0;
    cmd                    = '0;
    rx_escape_pending_next = rx_escape_pending;
    unique case (in_item.opcode)
      OpEncData: begin
        emit           = 1'b1;
        cmd.kind       = KindWire;
        if (in_item.data_byte == SyncCode) begin
          cmd.first_byte  = EscCode;
          cmd.second_byte = EscSyncCode;
          cmd.two         = 1'b1;
        end else if (in_item.data_byte == EscCode) begin
          cmd.first_byte  = EscCode;
          cmd.second_byte = EscEscCode;
          cmd.two         = 1'b1;
        end else begin
          cmd.first_byte = in_item.data_byte;
        end
      end
      OpEncSync: begin
        emit           = 1'b1;
        cmd.kind       = KindWire;
        cmd.first_byte = SyncCode;
      end
      OpDecode: begin
        if (in_item.data_byte == SyncCode) begin
          // Framing starts over, so a pending escape is dropped.
          emit                   = 1'b1;
          cmd.kind               = KindSync;
          cmd.first_byte         = SyncCode;
          rx_escape_pending_next = 1'b0;
        end else if (in_item.data_byte == EscCode) begin
          rx_escape_pending_next = 1'b1;
        end else begin
          emit           = 1'b1;
          cmd.kind       = KindData;
          cmd.first_byte = in_item.data_byte;
          if (rx_escape_pending) begin
            rx_escape_pending_next = 1'b0;
            if (in_item.data_byte == EscSyncCode) begin
              cmd.first_byte = SyncCode;
            end else if (in_item.data_byte == EscEscCode) begin
              cmd.first_byte = EscCode;
            end
          end
        end
      end
      default: begin
        // Unused opcode: no result and no state change.
      end
    endcase
  end

  assign push.valid = accept && emit;
  assign push.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_escape_pending <= 1'b0;
    end else if (accept) begin
      rx_escape_pending <= rx_escape_pending_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sebc_queue.sv
// ----------------------------------------------------------------------------
// sebc_queue
// Short register queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sebc_queue #(
  parameter int Depth = sebc_pkg::QueueDepthDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  sebc_pkg::cmd_push_t  push,
  output logic                 full,
  output logic                 not_empty,
  output sebc_pkg::cmd_t       head,
  input  wire                  pop
);
  import sebc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sebc_back.sv
// ----------------------------------------------------------------------------
// sebc_back
// Issues the one or two result items of each command from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sebc_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cmd_avail,
  input  sebc_pkg::cmd_t       cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sebc_pkg::out_item_t  out_item
);
  import sebc_pkg::*;

  logic       second_pending;
  logic [7:0] second_byte;
  logic [1:0] second_kind;
  logic       load;

  // The output register may take a new item when empty or being drained.
  assign load = !out_valid || out_ready;
  assign pop  = load && !second_pending && cmd_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      if (second_pending) begin
        out_valid      <= 1'b1;
        second_pending <= 1'b0;
      end else begin
        out_valid      <= cmd_avail;
        second_pending <= cmd_avail && cmd.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (second_pending) begin
        out_item.out_byte <= second_byte;
        out_item.out_kind <= second_kind;
        out_item.last     <= 1'b1;
      end else begin
        out_item.out_byte <= cmd.first_byte;
        out_item.out_kind <= cmd.kind;
        out_item.last     <= !cmd.two;
        second_byte       <= cmd.second_byte;
        second_kind       <= cmd.kind;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sync_escape_byte_stuffing_codec.sv
// ----------------------------------------------------------------------------
// sync_escape_byte_stuffing_codec
// Byte-stuffing encoder and decoder for a bus with sync 0xFF and escape 0x55.
// ----------------------------------------------------------------------------
// Each input item carries an opcode and a byte. Encoding a data byte sends it
// unchanged, except that 0xFF goes out as 0x55 0x00 and 0x55 as 0x55 0x01;
// encoding a sync sends a raw 0xFF. Decoding a wire byte reports 0xFF as a
// sync, swallows 0x55 as an escape, and after an escape turns 0x00 into 0xFF
// and 0x01 into 0x55. Opcode 3 and a received escape give no result item.
// The front end accepts one item per cycle as long as the command queue has
// room; the back end issues one result item per cycle from its single output
// register while out_ready is high, so the sustained rate is one input item
// per cycle for items with one result, and an escaped encode holds the next
// command until its second result is loaded. A result passes through the
// queue and then the output register: its command enters the queue when its
// item is accepted and moves on once the output register can load. The last
// field marks the final result item of each input item.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_escape_byte_stuffing_codec #(
  parameter int QUEUE_DEPTH = sebc_pkg::QueueDepthDefault
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  sebc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sebc_pkg::out_item_t  out_item
);
  import sebc_pkg::*;

  // Classified commands travel from the front end through the queue.
  cmd_push_t push;
  cmd_t      head;
  logic      queue_full;
  logic      queue_not_empty;
  logic      pop;

  // Front end: handshake, classification and the receive escape flag.
  sebc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .queue_full (queue_full),
    .push       (push)
  );

  // Queue that lets the input and output sides stall independently.
  sebc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head),
    .pop       (pop)
  );

  // Back end: expands each command into its result items.
  sebc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_avail (queue_not_empty),
    .cmd       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/core/sebc_checker.sv
// ----------------------------------------------------------------------------
// sebc_checker
// Port-level checks for the escape byte-stuffing codec, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sebc_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_ready,
  input sebc_pkg::out_item_t out_item
);
  import sebc_pkg::*;

  // A stalled result item holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  // The first item of a pair is always the escape byte on the wire.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |->
      out_item.out_byte == EscCode && out_item.out_kind == KindWire)
    else $error("non-final result is not a wire escape");

  // The second item of a pair follows right away.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.last |=>
      out_valid && out_item.last && out_item.out_kind == KindWire)
    else $error("second item of an escape pair missing");

  // A received sync is always reported as 0xFF on its own.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.out_kind == KindSync |->
      out_item.out_byte == SyncCode && out_item.last)
    else $error("malformed sync report");

  // Nothing is presented in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind sync_escape_byte_stuffing_codec sebc_checker u_sebc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
